// ===== src/gbts_pkg.sv =====
// ----------------------------------------------------------------------------
// gbts_pkg
// Shared constants, request and status codes of the gap-buffer text store.
// ----------------------------------------------------------------------------
package gbts_pkg;

  // store geometry
  localparam int CAPACITY = 4096;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int PTR_W    = 13;

  localparam logic [PTR_W-1:0] CAP_PTR = PTR_W'(CAPACITY);

  // field widths
  localparam int REQ_W   = 3;
  localparam int BYTE_W  = 8;
  localparam int INDEX_W = 12;
  localparam int STAT_W  = 2;

  // request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT    = 3'd0,
    REQ_LEFT      = 3'd1,
    REQ_RIGHT     = 3'd2,
    REQ_DEL_LEFT  = 3'd3,
    REQ_DEL_RIGHT = 3'd4,
    REQ_READ      = 3'd5
  } req_e_t;

  // status codes
  typedef enum logic [STAT_W-1:0] {
    ST_DONE     = 2'd0,
    ST_FULL     = 2'd1,
    ST_BOUNDARY = 2'd2,
    ST_RANGE    = 2'd3
  } status_t;

endpackage

// ===== src/gbts_req_if.sv =====
// ----------------------------------------------------------------------------
// gbts_req_if
// Request channel: valid/ready handshake with the request payload.
// ----------------------------------------------------------------------------
interface gbts_req_if
  import gbts_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [REQ_W-1:0]   req_type;
  logic [BYTE_W-1:0]  insert_byte;
  logic [INDEX_W-1:0] read_index;

  modport source (output valid, req_type, insert_byte, read_index, input ready);
  modport sink   (input valid, req_type, insert_byte, read_index, output ready);
endinterface

// ===== src/gbts_res_if.sv =====
// ----------------------------------------------------------------------------
// gbts_res_if
// Result channel: valid/ready handshake with the result payload.
// ----------------------------------------------------------------------------
interface gbts_res_if
  import gbts_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [BYTE_W-1:0] read_byte;
  logic [PTR_W-1:0]  text_length;
  logic [PTR_W-1:0]  cursor_position;

  modport source (output valid, status, read_byte, text_length, cursor_position,
                  input ready);
  modport sink   (input valid, status, read_byte, text_length, cursor_position,
                  output ready);
endinterface

// ===== src/gap_buffer_text_store_top.sv =====
// ----------------------------------------------------------------------------
// gap_buffer_text_store_top
// Gap-buffer text store: byte RAM plus gap start and gap end pointers.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake          | payload
//  in_req   | in  | valid/ready        | req_type, insert_byte, read_index
//  out_res  | out | valid/ready        | status, read_byte, text_length,
//           |     |                    | cursor_position
//
//  Inserts, deletes, boundary no-ops, full inserts, out-of-range reads and
//  unused codes go from accept to the output register once it is free.
//  Moves and in-range reads issue one RAM read at accept, then the result (and
//  for a move the write across the gap) on the single RAM port.
//  A new request is accepted once the previous one has left for the output
//  register, which holds a result while the sink stalls.
//  Reset is synchronous: empty text, cursor at 0; RAM contents are not cleared.
// ----------------------------------------------------------------------------
module gap_buffer_text_store_top
  import gbts_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  gbts_req_if.sink   in_req,
  gbts_res_if.source out_res
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_RDATA = 3'b010,
    S_HOLD  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  logic [PTR_W-1:0] gs_r, gs_nxt;
  logic [PTR_W-1:0] ge_r, ge_nxt;

  // pending result
  logic [STAT_W-1:0] pend_status_r, pend_status_nxt;
  logic [BYTE_W-1:0] pend_byte_r, pend_byte_nxt;
  logic              pend_move_r, pend_move_nxt;
  logic              pend_read_r, pend_read_nxt;
  logic [ADDR_W-1:0] wr_addr_r, wr_addr_nxt;

  // output register
  logic              out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0] out_status_r, out_status_nxt;
  logic [BYTE_W-1:0] out_byte_r, out_byte_nxt;
  logic [PTR_W-1:0]  out_len_r, out_len_nxt;
  logic [PTR_W-1:0]  out_cur_r, out_cur_nxt;

  // RAM port
  logic              mem_en;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_addr;
  logic [BYTE_W-1:0] mem_wdata;
  logic [BYTE_W-1:0] mem_rdata;

  // decode of the request at the input
  logic              accept;
  logic              out_free;
  logic [PTR_W-1:0]  len_cur;
  logic [PTR_W-1:0]  idx_ext;
  logic [PTR_W-1:0]  gap_size;
  logic [PTR_W-1:0]  rd_phys;
  logic [PTR_W-1:0]  gs_dec;
  logic [PTR_W-1:0]  ge_dec;
  logic [STAT_W-1:0] dec_status;
  logic              dec_need_mem;
  logic              dec_move;
  logic              dec_read;
  logic              dec_we;
  logic [ADDR_W-1:0] dec_addr;
  logic [ADDR_W-1:0] dec_wr_addr;

  assign accept   = in_req.valid && in_req.ready;
  assign out_free = !out_valid_r || out_res.ready;
  assign in_req.ready = (state_r == S_IDLE);

  assign len_cur  = gs_r + (CAP_PTR - ge_r);
  assign idx_ext  = PTR_W'(in_req.read_index);
  assign gap_size = ge_r - gs_r;
  assign rd_phys  = (idx_ext < gs_r) ? idx_ext : (idx_ext + gap_size);

  // request decode: pointer update, status and RAM access
  always_comb begin
    gs_dec       = gs_r;
    ge_dec       = ge_r;
    dec_status   = ST_DONE;
    dec_need_mem = 1'b0;
    dec_move     = 1'b0;
    dec_read     = 1'b0;
    dec_we       = 1'b0;
    dec_addr     = gs_r[ADDR_W-1:0];
    dec_wr_addr  = ge_r[ADDR_W-1:0];
    case (in_req.req_type)
      REQ_INSERT: begin
        if (gs_r == ge_r) begin
          dec_status = ST_FULL;
        end else begin
          dec_we = 1'b1;
          gs_dec = gs_r + PTR_W'(1);
        end
      end
      REQ_LEFT: begin
        if (gs_r == '0) begin
          dec_status = ST_BOUNDARY;
        end else begin
          gs_dec       = gs_r - PTR_W'(1);
          ge_dec       = ge_r - PTR_W'(1);
          dec_addr     = gs_dec[ADDR_W-1:0];
          dec_wr_addr  = ge_dec[ADDR_W-1:0];
          dec_need_mem = 1'b1;
          dec_move     = 1'b1;
        end
      end
      REQ_RIGHT: begin
        if (ge_r >= CAP_PTR) begin
          dec_status = ST_BOUNDARY;
        end else begin
          gs_dec       = gs_r + PTR_W'(1);
          ge_dec       = ge_r + PTR_W'(1);
          dec_addr     = ge_r[ADDR_W-1:0];
          dec_wr_addr  = gs_r[ADDR_W-1:0];
          dec_need_mem = 1'b1;
          dec_move     = 1'b1;
        end
      end
      REQ_DEL_LEFT: begin
        if (gs_r == '0) begin
          dec_status = ST_BOUNDARY;
        end else begin
          gs_dec = gs_r - PTR_W'(1);
        end
      end
      REQ_DEL_RIGHT: begin
        if (ge_r >= CAP_PTR) begin
          dec_status = ST_BOUNDARY;
        end else begin
          ge_dec = ge_r + PTR_W'(1);
        end
      end
      REQ_READ: begin
        if (idx_ext >= len_cur) begin
          dec_status = ST_RANGE;
        end else begin
          dec_addr     = rd_phys[ADDR_W-1:0];
          dec_need_mem = 1'b1;
          dec_read     = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // RAM port arbitration: accept cycle, then move write-back
  always_comb begin
    mem_en    = 1'b0;
    mem_we    = 1'b0;
    mem_addr  = dec_addr;
    mem_wdata = in_req.insert_byte;
    if (state_r == S_RDATA) begin
      mem_en    = pend_move_r;
      mem_we    = pend_move_r;
      mem_addr  = wr_addr_r;
      mem_wdata = mem_rdata;
    end else if (accept) begin
      mem_en = dec_we || dec_need_mem;
      mem_we = dec_we;
    end
  end

  gbts_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (BYTE_W)
  ) u_ram (
    .clk   (clk),
    .en    (mem_en),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // sequencing and result hand-off
  always_comb begin
    state_nxt       = state_r;
    gs_nxt          = gs_r;
    ge_nxt          = ge_r;
    pend_status_nxt = pend_status_r;
    pend_byte_nxt   = pend_byte_r;
    pend_move_nxt   = pend_move_r;
    pend_read_nxt   = pend_read_r;
    wr_addr_nxt     = wr_addr_r;
    out_valid_nxt   = out_valid_r && !out_res.ready;
    out_status_nxt  = out_status_r;
    out_byte_nxt    = out_byte_r;
    out_len_nxt     = out_len_r;
    out_cur_nxt     = out_cur_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          gs_nxt          = gs_dec;
          ge_nxt          = ge_dec;
          pend_status_nxt = dec_status;
          pend_byte_nxt   = '0;
          pend_move_nxt   = dec_move;
          pend_read_nxt   = dec_read;
          wr_addr_nxt     = dec_wr_addr;
          if (dec_need_mem) begin
            state_nxt = S_RDATA;
          end else if (out_free) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = dec_status;
            out_byte_nxt   = '0;
            out_len_nxt    = gs_dec + (CAP_PTR - ge_dec);
            out_cur_nxt    = gs_dec;
          end else begin
            state_nxt = S_HOLD;
          end
        end
      end
      S_RDATA: begin
        if (pend_read_r) begin
          pend_byte_nxt = mem_rdata;
        end
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = pend_status_r;
          out_byte_nxt   = pend_read_r ? mem_rdata : '0;
          out_len_nxt    = len_cur;
          out_cur_nxt    = gs_r;
          state_nxt      = S_IDLE;
        end else begin
          state_nxt = S_HOLD;
        end
      end
      S_HOLD: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = pend_status_r;
          out_byte_nxt   = pend_byte_r;
          out_len_nxt    = len_cur;
          out_cur_nxt    = gs_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      gs_r        <= '0;
      ge_r        <= CAP_PTR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      gs_r        <= gs_nxt;
      ge_r        <= ge_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pend_status_r <= pend_status_nxt;
    pend_byte_r   <= pend_byte_nxt;
    pend_move_r   <= pend_move_nxt;
    pend_read_r   <= pend_read_nxt;
    wr_addr_r     <= wr_addr_nxt;
    out_status_r  <= out_status_nxt;
    out_byte_r    <= out_byte_nxt;
    out_len_r     <= out_len_nxt;
    out_cur_r     <= out_cur_nxt;
  end

  assign out_res.valid           = out_valid_r;
  assign out_res.status          = out_status_r;
  assign out_res.read_byte       = out_byte_r;
  assign out_res.text_length     = out_len_r;
  assign out_res.cursor_position = out_cur_r;

`ifndef ASSERT_OFF
  // gap pointers stay ordered and inside the store
  a_gap_order: assert property (@(posedge clk) disable iff (!rst_n)
    (gs_r <= ge_r) && (ge_r <= CAP_PTR))
    else $error("gap pointers out of order");

  // reported cursor never exceeds reported length
  a_out_cursor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_cur_r <= out_len_r))
    else $error("cursor past text length in result");

  // the read-data phase is never repeated back to back
  a_rdata_once: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RDATA) |=> (state_r != S_RDATA))
    else $error("read-data phase repeated");

  // RAM writes only for an accepted insert or a move write-back
  a_ram_write: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (accept || (state_r == S_RDATA && pend_move_r)))
    else $error("unexpected RAM write");
`endif

endmodule

// ===== src/gbts_ram.sv =====
// ----------------------------------------------------------------------------
// gbts_ram
// Single-port synchronous RAM, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module gbts_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write, or read into the registered read data
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata_r <= mem[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule
